### src/tlbpt_pkg.sv
package tlbpt_pkg;

    localparam int ADDR_W      = 16;
    localparam int CNT_W       = 32;
    localparam int PAGE_COUNT  = 256;
    localparam int OFFSET_SPAN = 256;
    localparam int NUM_FRAMES  = 256;
    localparam int PAGE_W      = $clog2(PAGE_COUNT);
    localparam int OFFSET_W    = $clog2(OFFSET_SPAN);
    localparam int FRAME_W     = $clog2(NUM_FRAMES);

    localparam int TLB_ENTRIES_DEF = 16;

    typedef struct packed {
        logic [ADDR_W-1:0] logical_address;
    } t_in_item;

    typedef struct packed {
        logic [ADDR_W-1:0] physical_address;
        logic              tlb_hit;
        logic              page_fault;
        logic [PAGE_W-1:0] fetch_page;
        logic [CNT_W-1:0]  hit_total;
        logic [CNT_W-1:0]  fault_total;
    } t_out_item;

endpackage

### src/tlbpt_if.sv
interface tlbpt_in_if;
    logic                valid;
    logic                ready;
    tlbpt_pkg::t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface tlbpt_out_if;
    logic                 valid;
    logic                 ready;
    tlbpt_pkg::t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### src/tlbpt_ram.sv
module tlbpt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // read-first: a read at the written address returns the old word
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### src/tlb_page_table_translator.sv
// Logical-to-physical address translator: a fully associative TLB in front of a
// demand-paged page table.
// Input channel i_in (sink): one logical address per item; upper bits page, lower
// bits offset. Output channel o_out (source): physical address, TLB hit and page
// fault flags, the page to fetch on a fault, and running hit and fault counts.
// Pipeline: two register stages, the lookup stage and then the result register; an
// item accepted on i_in passes through both before its result shows on o_out.
// Throughput: one item per cycle while o_out.ready stays high. The page table RAM
// is read when the item is accepted; a page-table write by the item just ahead is
// forwarded, so back to back items to the same page see each other's mapping.
// A TLB miss installs the page in FIFO order; a page with no mapping takes the
// next frame (wrapping) and is reported as a fault.
// Reset (i_rst_n low, synchronous) empties both stages, invalidates all TLB and
// page-table entries and clears the frame counter, FIFO slot and counts.
// When o_out.ready is low a valid result register holds; the lookup stage can still
// take one more item, after which i_in.ready drops until the result is taken.
module tlb_page_table_translator #(
    parameter int TLB_ENTRIES = tlbpt_pkg::TLB_ENTRIES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    tlbpt_in_if.sink           i_in,
    tlbpt_out_if.source        o_out
);

    localparam int PAGE_W   = tlbpt_pkg::PAGE_W;
    localparam int OFFSET_W = tlbpt_pkg::OFFSET_W;
    localparam int FRAME_W  = tlbpt_pkg::FRAME_W;
    localparam int CNT_W    = tlbpt_pkg::CNT_W;
    localparam int SLOT_W   = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;

    // lookup stage
    logic                     r_b_vld;
    logic [PAGE_W-1:0]        r_page;
    logic [OFFSET_W-1:0]      r_offset;
    logic                     r_byp;
    logic [FRAME_W-1:0]       r_byp_frame;

    // TLB
    logic [TLB_ENTRIES-1:0]   r_tlb_vld;
    logic [PAGE_W-1:0]        r_tlb_tag   [TLB_ENTRIES];
    logic [FRAME_W-1:0]       r_tlb_frame [TLB_ENTRIES];
    logic [SLOT_W-1:0]        r_fill;

    // page table valid bits; frames live in the RAM
    logic [tlbpt_pkg::PAGE_COUNT-1:0] r_tbl_vld;

    logic [FRAME_W-1:0]       r_next_frame;
    logic [CNT_W-1:0]         r_hits;
    logic [CNT_W-1:0]         r_faults;

    logic                     r_o_vld;
    tlbpt_pkg::t_out_item     r_out;

    logic                     in_fire;
    logic                     b_adv;
    logic [PAGE_W-1:0]        in_page;
    logic                     hit;
    logic [FRAME_W-1:0]       hit_frame;
    logic [FRAME_W-1:0]       ram_rdata;
    logic [FRAME_W-1:0]       tbl_frame;
    logic                     tbl_valid;
    logic                     fault;
    logic [FRAME_W-1:0]       frame;
    logic                     wr_en;

    logic [FRAME_W-1:0]       n_next_frame;
    logic [SLOT_W-1:0]        n_fill;
    logic [CNT_W-1:0]         n_hits;
    logic [CNT_W-1:0]         n_faults;
    tlbpt_pkg::t_out_item     n_out;

    assign b_adv   = r_b_vld && (!r_o_vld || o_out.ready);
    assign i_in.ready = !r_b_vld || b_adv;
    assign in_fire = i_in.valid && i_in.ready;
    assign in_page = i_in.data.logical_address[OFFSET_W +: PAGE_W];

    // parallel tag compare, lowest matching entry wins
    always_comb begin
        hit       = 1'b0;
        hit_frame = '0;
        for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
            if (r_tlb_vld[i] && (r_tlb_tag[i] == r_page)) begin
                hit       = 1'b1;
                hit_frame = r_tlb_frame[i];
            end
        end
    end

    assign tbl_valid = r_tbl_vld[r_page];
    assign tbl_frame = r_byp ? r_byp_frame : ram_rdata;
    assign fault     = !hit && !tbl_valid;
    assign wr_en     = b_adv && fault;

    always_comb begin
        if (hit) begin
            frame = hit_frame;
        end else if (tbl_valid) begin
            frame = tbl_frame;
        end else begin
            frame = r_next_frame;
        end
    end

    always_comb begin
        n_next_frame = r_next_frame;
        n_fill       = r_fill;
        n_hits       = r_hits;
        n_faults     = r_faults;
        if (hit) begin
            n_hits = r_hits + 1'b1;
        end else begin
            n_fill = (r_fill == SLOT_W'(TLB_ENTRIES - 1)) ? '0 : r_fill + 1'b1;
        end
        if (fault) begin
            n_faults     = r_faults + 1'b1;
            n_next_frame = (r_next_frame == FRAME_W'(tlbpt_pkg::NUM_FRAMES - 1)) ?
                           '0 : r_next_frame + 1'b1;
        end
    end

    always_comb begin
        n_out.physical_address = {frame, r_offset};
        n_out.tlb_hit          = hit;
        n_out.page_fault       = fault;
        n_out.fetch_page       = fault ? r_page : '0;
        n_out.hit_total        = n_hits;
        n_out.fault_total      = n_faults;
    end

    tlbpt_ram #(
        .WIDTH (FRAME_W),
        .DEPTH (tlbpt_pkg::PAGE_COUNT)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (r_page),
        .i_wdata (r_next_frame),
        .i_re    (in_fire),
        .i_raddr (in_page),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld      <= 1'b0;
            r_o_vld      <= 1'b0;
            r_tlb_vld    <= '0;
            r_tbl_vld    <= '0;
            r_fill       <= '0;
            r_next_frame <= '0;
            r_hits       <= '0;
            r_faults     <= '0;
        end else begin
            if (in_fire) begin
                r_b_vld <= 1'b1;
            end else if (b_adv) begin
                r_b_vld <= 1'b0;
            end
            if (b_adv) begin
                r_o_vld <= 1'b1;
            end else if (o_out.ready) begin
                r_o_vld <= 1'b0;
            end
            if (b_adv) begin
                r_fill       <= n_fill;
                r_next_frame <= n_next_frame;
                r_hits       <= n_hits;
                r_faults     <= n_faults;
                if (!hit) begin
                    r_tlb_vld[r_fill] <= 1'b1;
                end
                if (fault) begin
                    r_tbl_vld[r_page] <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_page      <= in_page;
            r_offset    <= i_in.data.logical_address[OFFSET_W-1:0];
            // RAM read and the write of the item ahead share this edge
            r_byp       <= wr_en && (in_page == r_page);
            r_byp_frame <= r_next_frame;
        end
        if (b_adv) begin
            r_out <= n_out;
            if (!hit) begin
                r_tlb_tag[r_fill]   <= r_page;
                r_tlb_frame[r_fill] <= frame;
            end
        end
    end

    assign o_out.valid = r_o_vld;
    assign o_out.data  = r_out;

endmodule

### src/tlbpt_checker.sv
module tlbpt_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_out_valid,
    input logic                 i_out_ready,
    input tlbpt_pkg::t_out_item i_out_data
);

    // a result held by the receiver does not change
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_data)))
        else $error("result changed while stalled");

    // a fault is only possible on a TLB miss
    a_fault_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !(i_out_data.page_fault && i_out_data.tlb_hit))
        else $error("fault reported on a TLB hit");

    // fetch request only with a fault
    a_fetch_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_data.page_fault) |-> (i_out_data.fetch_page == '0))
        else $error("fetch page without fault");

    // consecutive results: fault count grows by exactly the fault flag
    a_fault_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_ready) ##1 (i_out_valid && $past(i_rst_n)) |->
        (i_out_data.fault_total - $past(i_out_data.fault_total) ==
         32'(i_out_data.page_fault)) || !$past(i_out_valid && i_out_ready))
        else $error("fault count out of step");

    // nothing is shown right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

endmodule

bind tlb_page_table_translator tlbpt_checker u_tlbpt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_data  (o_out.data)
);
